FILE: design/rc4fb_pkg.sv
package rc4fb_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_SCHEDULE = 2'd1,
        CMD_RESTART  = 2'd2,
        CMD_PROCESS  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KS_RD_I,
        ST_KS_WAIT_I,
        ST_KS_RD_J,
        ST_KS_WAIT_J,
        ST_KS_SWAP,
        ST_COPY,
        ST_P_RD_I,
        ST_P_RD_J,
        ST_P_SWAP,
        ST_P_RD_K,
        ST_P_OUT,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic   load_key;
        logic   take_in;
        logic   init_wr;
        logic   ks_rd_i;
        logic   ks_rd_j;
        logic   ks_wr_i;
        logic   ks_swap;
        logic   copy_step;
        logic   clear_ij;
        logic   p_rd_i;
        logic   p_rd_j;
        logic   p_swap;
        logic   p_rd_k;
        logic   p_out;
        logic   cnt_clr;
    } t_ctrl;

    typedef struct packed {
        logic   cnt_last;
    } t_stat;

    localparam logic [7:0] KEY_HEAD = 8'hC5;
    localparam logic [7:0] KEY_TAIL = 8'h3A;

    function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] r);
        logic [15:0] d;
        d = {v, v} << r;
        return d[15:8];
    endfunction

    function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] r);
        logic [15:0] d;
        d = {v, v} >> r;
        return d[7:0];
    endfunction

endpackage

FILE: design/rc4fb_datapath.sv
module rc4fb_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rc4fb_pkg::t_ctrl  i_ctrl,
    output rc4fb_pkg::t_stat  o_stat,
    input  logic              i_decrypt,
    input  logic [4:0]        i_key_index,
    input  logic [7:0]        i_data_byte,
    output logic [7:0]        o_out_byte
);
    import rc4fb_pkg::*;

    logic [7:0] key_mem  [32];
    logic [7:0] init_box [256];
    logic [7:0] work_box [256];

    logic [8:0] r_cnt;
    logic [7:0] r_i, r_j, r_a, r_b, r_ks_j, r_out, r_data;
    logic [7:0] r_key_q, r_init_q, r_work_q;
    logic [7:0] n_ks_j, n_pj, n_out, ks_key, copy_q;

    assign o_stat.cnt_last = r_cnt[8];
    assign o_out_byte      = r_out;

    // key byte for schedule position r_cnt, the 64-byte key repeats
    always_comb begin
        if (r_cnt[5:4] == 2'd0)
            ks_key = KEY_HEAD;
        else if (r_cnt[5:4] == 2'd3)
            ks_key = KEY_TAIL;
        else
            ks_key = r_key_q;
    end

    assign n_ks_j = r_ks_j + r_init_q + ks_key;
    assign n_pj   = r_j + r_work_q;

    always_comb begin
        if (i_decrypt)
            n_out = rotr8(r_data ^ r_work_q, r_b[2:0]);
        else
            n_out = rotl8(r_data, r_b[2:0]) ^ r_work_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_key)
            key_mem[i_key_index] <= i_data_byte;
        r_key_q <= key_mem[5'(r_cnt[7:0] - 8'd16)];
    end

    // initial box: one write port, one read port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.init_wr)
            init_box[r_cnt[7:0]] <= r_cnt[7:0];
        else if (i_ctrl.ks_swap)
            init_box[r_ks_j] <= r_a;
        else if (i_ctrl.ks_wr_i)
            init_box[r_cnt[7:0]] <= r_init_q;
        if (i_ctrl.ks_rd_j)
            r_init_q <= init_box[n_ks_j];
        else
            r_init_q <= init_box[r_cnt[7:0]];
    end

    assign copy_q = r_init_q;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.copy_step && r_cnt != 9'd0)
            work_box[8'(r_cnt - 9'd1)] <= copy_q;
        else if (i_ctrl.p_swap)
            work_box[r_i] <= r_work_q;
        else if (i_ctrl.p_rd_k)
            work_box[r_j] <= r_a;
        if (i_ctrl.p_rd_i)
            r_work_q <= work_box[8'(r_i + 8'd1)];
        else if (i_ctrl.p_rd_j)
            r_work_q <= work_box[n_pj];
        else if (i_ctrl.p_rd_k) begin
            // entry j is written on this same edge
            if (8'(r_a + r_b) == r_j)
                r_work_q <= r_a;
            else
                r_work_q <= work_box[8'(r_a + r_b)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_i    <= '0;
            r_j    <= '0;
            r_ks_j <= '0;
        end else begin
            if (i_ctrl.cnt_clr)
                r_cnt <= '0;
            else if (i_ctrl.init_wr || i_ctrl.ks_swap || i_ctrl.copy_step)
                r_cnt <= r_cnt + 9'd1;
            if (i_ctrl.cnt_clr && !i_ctrl.clear_ij)
                r_ks_j <= '0;
            if (i_ctrl.ks_rd_j)
                r_ks_j <= n_ks_j;
            if (i_ctrl.clear_ij) begin
                r_i <= '0;
                r_j <= '0;
            end
            if (i_ctrl.p_rd_i)
                r_i <= r_i + 8'd1;
            if (i_ctrl.p_rd_j)
                r_j <= n_pj;
            if (i_ctrl.p_out)
                r_j <= r_j + (i_decrypt ? r_data : n_out);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take_in)
            r_data <= i_data_byte;
        if (i_ctrl.ks_rd_i)
            r_a <= r_init_q;
        if (i_ctrl.p_rd_j)
            r_a <= r_work_q;
        if (i_ctrl.p_swap)
            r_b <= r_work_q;
        if (i_ctrl.p_out)
            r_out <= n_out;
    end

endmodule

FILE: design/rc4fb_ctrl.sv
module rc4fb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_command,
    output logic              o_valid,
    input  logic              i_ready,
    output rc4fb_pkg::t_ctrl  o_ctrl,
    input  rc4fb_pkg::t_stat  i_stat
);
    import rc4fb_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   r_boot, n_boot;
    t_cmd   cmd;

    assign cmd     = t_cmd'(i_command);
    assign o_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_ovalid <= 1'b0;
            r_boot   <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_boot   <= n_boot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_boot  = r_boot;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (cmd)
                        CMD_LOAD:     n_state = ST_IDLE;
                        CMD_SCHEDULE: n_state = ST_INIT;
                        CMD_RESTART:  n_state = ST_COPY;
                        CMD_PROCESS:  n_state = ST_P_RD_I;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_INIT:      if (i_stat.cnt_last) n_state = r_boot ? ST_COPY : ST_KS_RD_I;
            ST_KS_RD_I:   n_state = i_stat.cnt_last ? ST_HOLD : ST_KS_WAIT_I;
            ST_KS_WAIT_I: n_state = ST_KS_RD_J;
            ST_KS_RD_J:   n_state = ST_KS_WAIT_J;
            ST_KS_WAIT_J: n_state = ST_KS_SWAP;
            ST_KS_SWAP:   n_state = ST_KS_RD_I;
            ST_HOLD:      n_state = ST_COPY;
            ST_COPY: begin
                if (i_stat.cnt_last) begin
                    n_state = ST_IDLE;
                    n_boot  = 1'b0;
                end
            end
            ST_P_RD_I:    n_state = ST_P_RD_J;
            ST_P_RD_J:    n_state = ST_P_SWAP;
            ST_P_SWAP:    n_state = ST_P_RD_K;
            ST_P_RD_K:    n_state = ST_P_OUT;
            ST_P_OUT:     if (!r_ovalid || i_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl   = '0;
        o_ready  = 1'b0;
        n_ovalid = r_ovalid && !i_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctrl.cnt_clr  = 1'b1;
                    o_ctrl.take_in  = 1'b1;
                    o_ctrl.load_key = (cmd == CMD_LOAD);
                end
            end
            ST_INIT: begin
                o_ctrl.init_wr = !i_stat.cnt_last;
                o_ctrl.cnt_clr = i_stat.cnt_last;
            end
            ST_KS_RD_I:   o_ctrl = '0;
            ST_KS_WAIT_I: o_ctrl.ks_rd_i = 1'b1;
            ST_KS_RD_J:   o_ctrl.ks_rd_j = 1'b1;
            ST_KS_WAIT_J: o_ctrl.ks_wr_i = 1'b1;
            ST_KS_SWAP: begin
                o_ctrl.ks_swap = 1'b1;
            end
            ST_HOLD: begin
                o_ctrl.cnt_clr  = 1'b1;
                o_ctrl.clear_ij = 1'b1;
            end
            ST_COPY: begin
                o_ctrl.copy_step = !i_stat.cnt_last;
                o_ctrl.clear_ij  = 1'b1;
                if (i_stat.cnt_last)
                    o_ctrl.copy_step = 1'b1;
            end
            ST_P_RD_I:    o_ctrl.p_rd_i = 1'b1;
            ST_P_RD_J:    o_ctrl.p_rd_j = 1'b1;
            ST_P_SWAP:    o_ctrl.p_swap = 1'b1;
            ST_P_RD_K:    o_ctrl.p_rd_k = 1'b1;
            ST_P_OUT: begin
                // wait here while the previous result is still held
                if (!r_ovalid || i_ready) begin
                    o_ctrl.p_out = 1'b1;
                    n_ovalid     = 1'b1;
                end
            end
            default:      o_ctrl = '0;
        endcase
    end

endmodule

FILE: design/rc4_feedback_stream_cipher_unit.sv
// rc4 variant with ciphertext fed back into j
// input channel (i_valid/o_ready) carries i_command, i_key_index, i_data_byte;
// output channel (o_valid/i_ready) carries o_out_byte, one per process command
// load: one write to the key store. process: the result passes through the
// states P_RD_I, P_RD_J, P_SWAP, P_RD_K and P_OUT, set by the three dependent
// reads and the swap writes on the working box, one read and one write port;
// a new item is taken only once the last process has left P_OUT
// schedule: init, key mixing, clear and copy through the initial box port;
// restart: copy only. after reset the block builds and copies the identity
// box before it raises o_ready
// the user must write the decrypt mode bit via i_cfg_we/i_cfg_data only while
// idle; the block itself does not enforce this. a result waits in the output
// register while the receiver stalls; new items are still taken, and a further
// process holds in its last step until the waiting result has been transferred
// key hash bytes never loaded read as undefined
module rc4_feedback_stream_cipher_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [4:0] i_key_index,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte
);
    import rc4fb_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    logic  r_decrypt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_decrypt <= 1'b0;
        else if (i_cfg_we)
            r_decrypt <= i_cfg_data;
    end

    rc4fb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_ctrl    (ctrl),
        .i_stat    (stat)
    );

    rc4fb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_decrypt   (r_decrypt),
        .i_key_index (i_key_index),
        .i_data_byte (i_data_byte),
        .o_out_byte  (o_out_byte)
    );

endmodule

FILE: tb/sv/tb_rc4_feedback_stream_cipher_unit.sv
module tb_rc4_feedback_stream_cipher_unit;
    import rc4fb_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_data = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_command = CMD_LOAD;
    logic [4:0] i_key_index = '0;
    logic [7:0] i_data_byte = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_byte;

    rc4_feedback_stream_cipher_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_key_index (i_key_index),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [7:0] hash_bytes [32];
    logic [7:0] init_sbox [256];
    logic [7:0] work_sbox [256];
    logic [7:0] ci, cj;
    logic       mode_dec;
    logic [7:0] cipher_q [$];
    int         n_err, n_in, n_out, n_proc, n_sched;
    bit         hash_ok;
    bit         sender_hold;

    // the 64-byte key repeats over the 256 schedule positions
    function automatic logic [7:0] key_at(int pos);
        int p;
        p = pos & 63;
        if (p < 16) return 8'hC5;
        if (p < 48) return hash_bytes[p - 16];
        return 8'h3A;
    endfunction

    task automatic copy_box();
        for (int n = 0; n < 256; n++) work_sbox[n] = init_sbox[n];
        ci = '0;
        cj = '0;
    endtask

    task automatic predict_cipher(input t_cmd cmd, input logic [4:0] idx,
                                  input logic [7:0] d);
        logic [7:0] a, b, k, c, jj, t;
        logic [15:0] w;
        case (cmd)
            CMD_LOAD: hash_bytes[idx] = d;
            CMD_SCHEDULE: begin
                jj = '0;
                for (int n = 0; n < 256; n++) init_sbox[n] = n[7:0];
                for (int n = 0; n < 256; n++) begin
                    a = init_sbox[n];
                    jj = jj + a + key_at(n);
                    init_sbox[n] = init_sbox[jj];
                    init_sbox[jj] = a;
                end
                copy_box();
            end
            CMD_RESTART: copy_box();
            default: begin
                ci = ci + 8'd1;
                a = work_sbox[ci];
                cj = cj + a;
                b = work_sbox[cj];
                work_sbox[ci] = b;
                work_sbox[cj] = a;
                k = work_sbox[8'(a + b)];
                if (!mode_dec) begin
                    w = {d, d} << b[2:0];
                    c = w[15:8] ^ k;
                    cj = cj + c;
                end else begin
                    cj = cj + d;
                    t = d ^ k;
                    w = {t, t} >> b[2:0];
                    c = w[7:0];
                end
                cipher_q.push_back(c);
            end
        endcase
    endtask

    // receiver: stall pattern, check each transfer
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            n_out++;
            if (cipher_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %h", o_out_byte);
            end else begin
                if (o_out_byte !== cipher_q[0]) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("out_byte mismatch: exp %h got %h", cipher_q[0], o_out_byte);
                end
                void'(cipher_q.pop_front());
            end
        end
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            2: i_ready <= ($urandom_range(0, 1) != 0);
            default: i_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    int burst_left = 0;

    task automatic send(input t_cmd cmd, input logic [4:0] idx, input logic [7:0] d);
        int gap;
        // random gaps between bursts
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? 0 : int'($urandom_range(1, 12));
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_command <= cmd;
        i_key_index <= idx;
        i_data_byte <= d;
        do @(posedge i_clk); while (!(o_ready === 1'b1));
        predict_cipher(cmd, idx, d);
        n_in++;
        if (cmd == CMD_PROCESS) n_proc++;
        if (cmd == CMD_SCHEDULE) n_sched++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        // schedule or restart may still be running after the last result
        repeat (2000) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        i_valid <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_dec = m;
    endtask

    typedef struct {
        t_cmd       cmd;
        logic [4:0] idx;
        logic [7:0] d;
        bit         chk;
        logic [7:0] res;
    } t_row;

    // process on the identity box straight after reset: i=1, a=1, j=1, b=1,
    // k=S[2]=2, rotate by 1
    t_row dir_rows [] = '{
        '{CMD_PROCESS, 5'd0,  8'h00, 1'b1, 8'h02},
        '{CMD_PROCESS, 5'd31, 8'hFF, 1'b0, 8'h00},
        '{CMD_RESTART, 5'd0,  8'h00, 1'b0, 8'h00},
        '{CMD_PROCESS, 5'd0,  8'h80, 1'b1, 8'h03},
        '{CMD_PROCESS, 5'd0,  8'hA5, 1'b0, 8'h00},
        '{CMD_PROCESS, 5'd0,  8'h5A, 1'b0, 8'h00}
    };

    task automatic load_hash();
        for (int n = 0; n < 32; n++) send(CMD_LOAD, n[4:0], 8'($urandom));
        hash_ok = 1'b1;
    endtask

    task automatic rand_items(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 80) send(CMD_PROCESS, 5'($urandom), 8'($urandom));
            else if (r < 88) send(CMD_LOAD, 5'($urandom), 8'($urandom));
            else if (r < 95) send(CMD_RESTART, 5'($urandom), 8'($urandom));
            else if (hash_ok) send(CMD_SCHEDULE, 5'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        for (int n = 0; n < 256; n++) begin
            init_sbox[n] = n[7:0];
            work_sbox[n] = n[7:0];
        end
        ci = '0; cj = '0; mode_dec = 1'b0;
        n_err = 0; n_in = 0; n_out = 0; n_proc = 0; n_sched = 0;
        hash_ok = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_mode(1'b0);
        foreach (dir_rows[n]) begin
            if (dir_rows[n].chk) begin
                // fixed value, predictor must agree with it
                send(dir_rows[n].cmd, dir_rows[n].idx, dir_rows[n].d);
                if (cipher_q[$] !== dir_rows[n].res) begin
                    n_err++;
                    $display("directed row %0d: exp %h predicted %h", n,
                             dir_rows[n].res, cipher_q[$]);
                end
            end else begin
                send(dir_rows[n].cmd, dir_rows[n].idx, dir_rows[n].d);
            end
        end
        load_hash();
        send(CMD_SCHEDULE, 5'd0, 8'h00);
        for (int n = 0; n < 6; n++) send(CMD_PROCESS, 5'd0, n[0] ? 8'hFF : 8'h00);
        drain();
        set_mode(1'b1);
        send(CMD_RESTART, 5'd0, 8'h00);
        for (int n = 0; n < 6; n++) send(CMD_PROCESS, 5'd31, 8'($urandom));
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            set_mode(ph[0]);
            rand_items(300);
            drain();
        end
        $display("%0d items sent (%0d process, %0d schedule), %0d results checked",
                 n_in, n_proc, n_sched, n_out);
        $display("both cipher directions covered, with gaps and output stalls");
        if (n_err == 0 && cipher_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
